// ===== sv/hcb_pkg.sv =====
// types and constants shared by the huffman code builder
package hcb_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 63;
    localparam int WEIGHT_W = 32;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_value;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic              count_saturated;
    } t_out_item;

endpackage

// ===== sv/hcb_ifs.sv =====
// valid/ready channels for input items and result items
interface hcb_in_if;
    import hcb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface hcb_out_if;
    import hcb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/hcb_ram.sv =====
// generic single write port ram with registered read
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/huffman_code_builder_core.sv =====
// huffman code builder: byte histogram, tree build by repeated min scan, code table
// a message byte is counted in S_CNT, a query is answered from S_QRD; input is ready only in S_IDLE
// a query waits in its read state while the previous result beat is still held
// build after the last byte: slot setup alternates S_IRD and S_IWR per symbol, then per
// merge one S_SCAN over all slots, S_MRG and S_MRG2, then per symbol S_CWK/S_CSP per tree level
// reset (synchronous, active low) empties the histogram and drops the built table
module huffman_code_builder_core #(
    parameter int SYMBOLS      = 256,
    parameter int COUNT_WIDTH  = 24,
    parameter int MAX_CODE_LEN = 63
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcb_in_if.sink    i_in,
    hcb_out_if.source o_out
);
    import hcb_pkg::*;

    localparam int SW    = $clog2(SYMBOLS);
    localparam int NODES = 2 * SYMBOLS - 1;
    localparam int NW    = $clog2(NODES);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_CNT  = 11'b00000000010,
        S_IRD  = 11'b00000000100,
        S_IWR  = 11'b00000001000,
        S_SCAN = 11'b00000010000,
        S_MRG  = 11'b00000100000,
        S_MRG2 = 11'b00001000000,
        S_CST  = 11'b00010000000,
        S_CWK  = 11'b00100000000,
        S_CSP  = 11'b01000000000,
        S_QRD  = 11'b10000000000
    } t_state;

    t_state            r_state;
    logic [SYMBOLS-1:0] r_hv;
    logic [SYMBOLS-1:0] r_sv;
    logic              r_ready_tbl;
    logic              r_sat;
    logic              r_ovalid;
    t_out_item         r_oitem;
    logic [SW-1:0]     r_sym;
    logic              r_inr;
    logic              r_last;
    logic              r_qf;
    logic [SW:0]       r_idx;
    logic [SW-1:0]     r_didx;
    logic              r_dv;
    logic              r_h1, r_h2;
    logic [WEIGHT_W-1:0] r_w1, r_w2;
    logic [SW-1:0]     r_a1, r_a2;
    logic [NW-1:0]     r_n1, r_n2;
    logic [NW-1:0]     r_next;
    logic [NW-1:0]     r_root;
    logic [NW-1:0]     r_n;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_bits;
    logic [CODE_W-1:0] r_mask;

    logic                   h_we;
    logic [SW-1:0]          h_waddr, h_raddr;
    logic [COUNT_WIDTH-1:0] h_wdata, h_rdata;
    logic                   s_we;
    logic [SW-1:0]          s_waddr, s_raddr;
    logic [WEIGHT_W+NW-1:0] s_wdata, s_rdata;
    logic                   nd_we;
    logic [NW-1:0]          nd_waddr, nd_raddr;
    logic [NW:0]            nd_wdata, nd_rdata;
    logic                   c_we;
    logic [SW-1:0]          c_waddr, c_raddr;
    logic [LEN_W+CODE_W-1:0] c_wdata, c_rdata;

    logic                   accept;
    logic                   in_range;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [WEIGHT_W-1:0]    scan_w;
    logic [NW-1:0]          scan_n;
    logic [WEIGHT_W:0]      sum;
    logic [WEIGHT_W-1:0]    sum_sat;
    logic                   walk_done;

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign in_range    = {1'b0, i_in.data.byte_value} < (BYTE_W + 1)'(SYMBOLS);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oitem;

    assign cur_cnt = (r_inr && r_hv[r_sym]) ? h_rdata : '0;
    assign scan_w  = s_rdata[WEIGHT_W+NW-1:NW];
    assign scan_n  = s_rdata[NW-1:0];
    assign sum     = {1'b0, r_w1} + {1'b0, r_w2};
    assign sum_sat = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
    assign walk_done = (r_n == r_root) || (r_len == LEN_W'(MAX_CODE_LEN));

    always_comb begin
        h_raddr  = (r_state == S_IDLE) ? i_in.data.byte_value[SW-1:0] : r_idx[SW-1:0];
        h_we     = (r_state == S_CNT) && r_inr && (cur_cnt != '1);
        h_waddr  = r_sym;
        h_wdata  = cur_cnt + COUNT_WIDTH'(1);

        s_raddr  = r_idx[SW-1:0];
        s_we     = (r_state == S_IWR) || ((r_state == S_MRG) && r_h1 && r_h2);
        if (r_state == S_IWR) begin
            s_waddr = r_idx[SW-1:0];
            s_wdata = {(r_hv[r_idx[SW-1:0]] ? WEIGHT_W'(h_rdata) : WEIGHT_W'(0)),
                       NW'(r_idx)};
        end else begin
            s_waddr = r_a1;
            s_wdata = {sum_sat, r_next};
        end

        nd_raddr = r_n;
        nd_we    = ((r_state == S_MRG) && r_h1 && r_h2) || (r_state == S_MRG2);
        if (r_state == S_MRG2) begin
            nd_waddr = r_n2;
            nd_wdata = {r_next, 1'b1};
        end else begin
            nd_waddr = r_n1;
            nd_wdata = {r_next, 1'b0};
        end

        c_raddr = (r_state == S_IDLE) ? i_in.data.byte_value[SW-1:0] : r_sym;
        c_we    = (r_state == S_CWK) && walk_done;
        c_waddr = r_idx[SW-1:0];
        c_wdata = {r_len, r_bits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hv        <= '0;
            r_ready_tbl <= 1'b0;
            r_sat       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && (r_state != S_QRD)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sym  <= i_in.data.byte_value[SW-1:0];
                        r_inr  <= in_range;
                        r_last <= i_in.data.last;
                        if (i_in.data.kind == KIND_BYTE) begin
                            if (r_ready_tbl) begin
                                r_hv        <= '0;
                                r_sat       <= 1'b0;
                                r_ready_tbl <= 1'b0;
                            end
                            r_state <= S_CNT;
                        end else begin
                            r_qf    <= r_ready_tbl && in_range &&
                                       r_hv[i_in.data.byte_value[SW-1:0]];
                            r_state <= S_QRD;
                        end
                    end
                end
                S_CNT: begin
                    if (r_inr) begin
                        if (cur_cnt == '1) begin
                            r_sat <= 1'b1;
                        end else begin
                            r_hv[r_sym] <= 1'b1;
                        end
                    end
                    r_idx   <= '0;
                    r_state <= r_last ? S_IRD : S_IDLE;
                end
                S_IRD: begin
                    r_state <= S_IWR;
                end
                S_IWR: begin
                    r_sv[r_idx[SW-1:0]] <= r_hv[r_idx[SW-1:0]];
                    if (r_idx == (SW + 1)'(SYMBOLS - 1)) begin
                        r_idx   <= '0;
                        r_dv    <= 1'b0;
                        r_h1    <= 1'b0;
                        r_h2    <= 1'b0;
                        r_next  <= NW'(SYMBOLS);
                        r_state <= S_SCAN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_IRD;
                    end
                end
                S_SCAN: begin
                    if (r_dv && r_sv[r_didx]) begin
                        if (!r_h1 || scan_w < r_w1) begin
                            r_h2 <= r_h1;
                            r_w2 <= r_w1;
                            r_a2 <= r_a1;
                            r_n2 <= r_n1;
                            r_h1 <= 1'b1;
                            r_w1 <= scan_w;
                            r_a1 <= r_didx;
                            r_n1 <= scan_n;
                        end else if (!r_h2 || scan_w < r_w2) begin
                            r_h2 <= 1'b1;
                            r_w2 <= scan_w;
                            r_a2 <= r_didx;
                            r_n2 <= scan_n;
                        end
                    end
                    if (r_idx == (SW + 1)'(SYMBOLS)) begin
                        r_dv    <= 1'b0;
                        r_state <= S_MRG;
                    end else begin
                        r_dv   <= 1'b1;
                        r_didx <= r_idx[SW-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                S_MRG: begin
                    if (!r_h1) begin
                        r_state <= S_IDLE;
                    end else if (!r_h2) begin
                        r_root  <= r_n1;
                        r_idx   <= '0;
                        r_state <= S_CST;
                    end else begin
                        r_sv[r_a2] <= 1'b0;
                        r_state    <= S_MRG2;
                    end
                end
                S_MRG2: begin
                    r_next  <= r_next + 1'b1;
                    r_idx   <= '0;
                    r_dv    <= 1'b0;
                    r_h1    <= 1'b0;
                    r_h2    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_CST: begin
                    if (r_idx == (SW + 1)'(SYMBOLS)) begin
                        r_ready_tbl <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (!r_hv[r_idx[SW-1:0]]) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_n     <= NW'(r_idx);
                        r_len   <= '0;
                        r_bits  <= '0;
                        r_mask  <= CODE_W'(1);
                        r_state <= S_CWK;
                    end
                end
                S_CWK: begin
                    if (walk_done) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CST;
                    end else begin
                        r_state <= S_CSP;
                    end
                end
                S_CSP: begin
                    if (nd_rdata[0]) begin
                        r_bits <= r_bits | r_mask;
                    end
                    r_mask  <= r_mask << 1;
                    r_len   <= r_len + 1'b1;
                    r_n     <= nd_rdata[NW:1];
                    r_state <= S_CWK;
                end
                S_QRD: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_oitem.found           <= r_qf;
                        r_oitem.code_length     <= r_qf ? c_rdata[LEN_W+CODE_W-1:CODE_W] : '0;
                        r_oitem.code_bits       <= r_qf ? c_rdata[CODE_W-1:0] : '0;
                        r_oitem.count_saturated <= r_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    hcb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYMBOLS)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    hcb_ram #(.WIDTH(WEIGHT_W + NW), .DEPTH(SYMBOLS)) u_slot (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    hcb_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    hcb_ram #(.WIDTH(LEN_W + CODE_W), .DEPTH(SYMBOLS)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
endmodule

// ===== tb/sv/tb_huffman_code_builder_core.sv =====
// testbench for huffman_code_builder_core: directed and random messages and code queries checked against a tree model
`timescale 1ns / 100ps

module tb_huffman_code_builder_core;
    import hcb_pkg::*;

    localparam int  NSYM      = 256;
    localparam int  NODES     = 511;
    localparam int  CNT_MAX   = (1 << 24) - 1;
    localparam int  LIMIT     = 4000000;
    localparam int  ITEMS     = 900;

    logic i_clk;
    logic i_rst_n;
    hcb_in_if  in_ch();
    hcb_out_if out_ch();

    huffman_code_builder_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // model of the histogram, tree and code table
    int unsigned     hist[NSYM];
    int unsigned     slot_wt[NSYM];
    int              slot_nd[NSYM];
    bit              slot_live[NSYM];
    int              parent[NODES];
    bit              branch[NODES];
    int              code_len[NSYM];
    logic [CODE_W-1:0] code_word[NSYM];
    bit              built;
    bit              sat_seen;

    t_out_item code_expect[$];
    int  n_items;
    int  n_results;
    int  n_builds;
    int  n_errors;
    int  cycles;
    int  src_idle;
    int  sink_stall;
    int  hold_left;

    function automatic int lowest_slot();
        int best;
        best = -1;
        for (int i = 0; i < NSYM; i++) begin
            if (slot_live[i] && (best < 0 || slot_wt[best] > slot_wt[i])) best = i;
        end
        return best;
    endfunction

    function automatic void build_code_table();
        int a;
        int b;
        int nxt;
        int root;
        int n;
        int len;
        int steps;
        logic [63:0] bits;
        logic [32:0] sum;
        nxt = NSYM;
        for (int i = 0; i < NSYM; i++) begin
            slot_live[i] = hist[i] > 0;
            slot_wt[i]   = slot_live[i] ? hist[i] : 0;
            slot_nd[i]   = i;
        end
        if (lowest_slot() < 0) return;
        forever begin
            a = lowest_slot();
            slot_live[a] = 1'b0;
            b = lowest_slot();
            if (b < 0 || nxt >= NODES) begin
                root = slot_nd[a];
                break;
            end
            slot_live[b] = 1'b0;
            parent[slot_nd[a]] = nxt;
            branch[slot_nd[a]] = 1'b0;
            parent[slot_nd[b]] = nxt;
            branch[slot_nd[b]] = 1'b1;
            sum = {1'b0, slot_wt[a]} + {1'b0, slot_wt[b]};
            slot_wt[a] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            slot_nd[a] = nxt;
            slot_live[a] = 1'b1;
            nxt++;
        end
        parent[root] = root;
        for (int i = 0; i < NSYM; i++) begin
            code_len[i]  = 0;
            code_word[i] = '0;
            if (hist[i] == 0) continue;
            n = i;
            len = 0;
            steps = 0;
            bits = '0;
            while (n != root && n < NODES && steps < NODES) begin
                if (len < CODE_W) begin
                    bits[len] = branch[n];
                    len++;
                end
                n = parent[n];
                steps++;
            end
            code_len[i]  = len;
            code_word[i] = bits[CODE_W-1:0];
        end
        built = 1'b1;
        n_builds++;
    endfunction

    function automatic void predict(t_in_item it);
        t_out_item r;
        if (it.kind == KIND_BYTE) begin
            if (built) begin
                foreach (hist[i]) hist[i] = 0;
                sat_seen = 1'b0;
                built = 1'b0;
            end
            if (hist[it.byte_value] >= CNT_MAX) sat_seen = 1'b1;
            else hist[it.byte_value]++;
            if (it.last) build_code_table();
        end else begin
            r = '0;
            if (built && hist[it.byte_value] > 0) begin
                r.found       = 1'b1;
                r.code_length = code_len[it.byte_value][LEN_W-1:0];
                r.code_bits   = code_word[it.byte_value];
            end
            r.count_saturated = sat_seen;
            code_expect.push_back(r);
        end
    endfunction

    task automatic send_item(logic k, logic [7:0] v, logic l);
        t_in_item it;
        it = '{kind: k, byte_value: v, last: l};
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict(it);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        end_burst();
        while (code_expect.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic send_message(int len, int lo, int hi);
        for (int i = 0; i < len; i++)
            send_item(KIND_BYTE, 8'($urandom_range(hi, lo)), i == len - 1);
    endtask

    task automatic query_some(int cnt, int lo, int hi);
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(9) == 0) send_item(KIND_QUERY, 8'($urandom), 1'b0);
            else send_item(KIND_QUERY, 8'($urandom_range(hi, lo)), 1'b0);
        end
    endtask

    task automatic test_directed();
        send_item(KIND_QUERY, 8'h00, 1'b0);
        send_item(KIND_BYTE, 8'h00, 1'b0);
        send_item(KIND_BYTE, 8'hFF, 1'b0);
        send_item(KIND_BYTE, 8'h55, 1'b0);
        send_item(KIND_BYTE, 8'hAA, 1'b0);
        send_item(KIND_BYTE, 8'h00, 1'b1);
        send_item(KIND_QUERY, 8'h00, 1'b0);
        send_item(KIND_QUERY, 8'hFF, 1'b0);
        send_item(KIND_QUERY, 8'h55, 1'b0);
        send_item(KIND_QUERY, 8'hAA, 1'b0);
        send_item(KIND_QUERY, 8'h01, 1'b0);
        // single symbol message gets a zero length code
        send_item(KIND_BYTE, 8'h07, 1'b0);
        send_item(KIND_QUERY, 8'h07, 1'b0);
        send_item(KIND_BYTE, 8'h07, 1'b1);
        send_item(KIND_QUERY, 8'h07, 1'b0);
        send_item(KIND_QUERY, 8'h08, 1'b0);
        send_item(KIND_BYTE, 8'hFF, 1'b1);
        send_item(KIND_QUERY, 8'hFF, 1'b0);
        send_item(KIND_QUERY, 8'h07, 1'b0);
        wait_drained();
    endtask

    // fibonacci-like counts give a deep, lopsided tree
    task automatic test_deep_tree();
        int fib[10] = '{1, 1, 2, 3, 5, 8, 13, 21, 34, 55};
        int left[10];
        int total;
        int s;
        left = fib;
        total = 0;
        foreach (fib[i]) total += fib[i];
        for (int k = 0; k < total; k++) begin
            do s = $urandom_range(9); while (left[s] == 0);
            left[s]--;
            send_item(KIND_BYTE, 8'(8'hF0 + s), k == total - 1);
        end
        for (int i = 0; i < 10; i++) send_item(KIND_QUERY, 8'(8'hF0 + i), 1'b0);
        wait_drained();
    endtask

    task automatic test_full_alphabet();
        for (int i = 0; i < NSYM; i++) send_item(KIND_BYTE, 8'(i), 1'b0);
        send_message(10, 0, 255);
        query_some(20, 0, 255);
        wait_drained();
    endtask

    task automatic test_random(int target, int idle, int stall);
        int lo;
        int span;
        src_idle = idle;
        sink_stall = stall;
        target += n_items;
        while (n_items < target) begin
            lo = $urandom_range(255);
            span = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            if (lo + span > 255) lo = 255 - span;
            if ($urandom_range(7) == 0) begin
                send_message($urandom_range(6, 1), lo, lo + span);
                query_some($urandom_range(2), lo, lo + span);
                send_item(KIND_BYTE, 8'($urandom), 1'b0);
            end
            send_message($urandom_range(30, 1), lo, lo + span);
            query_some($urandom_range(12, 2), lo, lo + span);
        end
        wait_drained();
    endtask

    task automatic test_pressure();
        src_idle = 0;
        sink_stall = 0;
        send_message(20, 16, 31);
        hold_left = 400;
        query_some(40, 16, 31);
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= i_rst_n && ($urandom_range(99) >= sink_stall);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (code_expect.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                exp_r = code_expect.pop_front();
                if (out_ch.data.found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, out_ch.data.found);
                    n_errors++;
                end
                if (out_ch.data.code_length !== exp_r.code_length) begin
                    $error("code_length: expected %0d, got %0d",
                           exp_r.code_length, out_ch.data.code_length);
                    n_errors++;
                end
                if (out_ch.data.code_bits !== exp_r.code_bits) begin
                    $error("code_bits: expected %h, got %h",
                           exp_r.code_bits, out_ch.data.code_bits);
                    n_errors++;
                end
                if (out_ch.data.count_saturated !== exp_r.count_saturated) begin
                    $error("count_saturated: expected %0d, got %0d",
                           exp_r.count_saturated, out_ch.data.count_saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_huffman_code_builder_core failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        hold_left = 0;
        n_items = 0;
        n_results = 0;
        n_builds = 0;
        n_errors = 0;
        src_idle = 0;
        sink_stall = 0;
        built = 1'b0;
        sat_seen = 1'b0;
        foreach (hist[i]) hist[i] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_deep_tree();
        test_full_alphabet();
        test_pressure();
        test_random(ITEMS / 10, 0, 0);
        test_random(ITEMS / 10, 69, 0);
        test_random(ITEMS / 10, 0, 69);
        test_random(ITEMS / 10, 20, 20);

        while (code_expect.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("%0d items sent, %0d code queries answered, %0d trees built",
                 n_items, n_results, n_builds);
        $display("covered single symbol, deep tree, full alphabet, backpressure and idle mixes");
        if (n_errors == 0 && code_expect.size() == 0) begin
            $display("tb_huffman_code_builder_core passed");
        end else begin
            $display("tb_huffman_code_builder_core failed");
        end
        $finish;
    end

endmodule
